@@ hw/rtl/position_weighted_string_hash_core_assert.svh @@
// Assertion macros shared by the string hash RTL.
`ifndef POSITION_WEIGHTED_STRING_HASH_CORE_ASSERT_SVH
`define POSITION_WEIGHTED_STRING_HASH_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PWSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PWSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PWSH_ASSERT(lbl, prop, msg)
`define PWSH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hw/rtl/pwsh_pkg.sv @@
// Types and constants shared by the string hash modules.
`default_nettype none
package pwsh_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned SumW  = 64;
  localparam int unsigned CharW = 8;

  localparam logic [DataW-1:0] MAGIC_RESET   = 32'd47;
  localparam logic [DataW-1:0] BUCKETS_RESET = 32'd1024;

  // Configuration register indexes.
  localparam logic CFG_HASH_MAGIC   = 1'b0;
  localparam logic CFG_BUCKET_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } pwsh_state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic clear;
  } pwsh_acc_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pwsh_div_sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/position_weighted_string_hash_core.sv @@
// Top level of the position-weighted string hash: sequencer, registers and ports.
//
// Channel  Dir  Fields (low bit first)
// in_      in   tdata: char_byte[7:0]; tuser: has_char; tlast: last_char
// out_     out  tdata: bucket[31:0]
// cfg_     in   index 0 hash_magic, index 1 bucket_count, wdata 32 bits
//
// A byte that does not end a string passes through the latch, multiply and accumulate steps.
// A byte that ends a string then goes on through a load step, 64 remainder steps,
// a step to see the remainder done and a step to write the output register.
// The result waits in the output register; new bytes are taken while it waits,
// but the next finished remainder holds until out_tready frees that register.
// Reset is synchronous and active low; it restores hash_magic 47, bucket_count 1024.
`default_nettype none
`include "position_weighted_string_hash_core_assert.svh"
module position_weighted_string_hash_core
  import pwsh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // char_byte[7:0]
  input  wire logic              in_tuser,   // has_char
  input  wire logic              in_tlast,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [31:0]       out_tdata,  // bucket[31:0]
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [31:0]       cfg_wdata
);

  pwsh_state_t       state_r, state_nxt;
  logic [DataW-1:0]  magic_r, buckets_r;
  logic [CharW-1:0]  char_r;
  logic              has_r, last_r;
  logic              out_valid_r, out_valid_nxt;
  logic [DataW-1:0]  out_data_r;
  logic              in_accept;
  logic              out_load;
  logic              div_start;
  pwsh_acc_ctl_t     acc_ctl;
  pwsh_div_sts_t     div_sts;
  logic [SumW-1:0]   acc_sum;
  logic [DataW-1:0]  div_rem;

  pwsh_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (acc_ctl),
    .char_byte  (char_r),
    .hash_magic (magic_r),
    .sum        (acc_sum)
  );

  pwsh_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (acc_sum),
    .divisor   (buckets_r),
    .sts       (div_sts),
    .remainder (div_rem)
  );

  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    state_nxt      = state_r;
    in_tready      = 1'b0;
    acc_ctl        = '0;
    div_start      = 1'b0;
    out_load       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_ctl.mul_en = 1'b1;
        state_nxt      = ST_ADD;
      end
      ST_ADD: begin
        acc_ctl.acc_en = has_r;
        state_nxt      = last_r ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          acc_ctl.clear = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= MAGIC_RESET;
      buckets_r <= BUCKETS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HASH_MAGIC:   magic_r   <= cfg_wdata;
        CFG_BUCKET_COUNT: buckets_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_r  <= 1'b0;
      last_r <= 1'b0;
    end else if (in_accept) begin
      has_r  <= in_tuser;
      last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      char_r <= in_tdata;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // A zero bucket count reports bucket 0.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= (buckets_r == '0) ? '0 : div_rem;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `PWSH_ASSERT(a_out_source, $rose(out_valid_r) |-> $past(state_r == ST_OUT), "stray result word")
  `PWSH_ASSERT_NEXT(a_clear_sum, out_load, acc_sum == '0, "running sum not cleared after a result")
  `PWSH_ASSERT_NEXT(a_accept_mul, in_accept, state_r == ST_MUL, "accepted word skipped the multiply")
  `PWSH_ASSERT(a_div_busy, (state_r == ST_DIV && !div_sts.done) |-> div_sts.busy, "remainder unit idle")

endmodule
`default_nettype wire

@@ hw/rtl/pwsh_accum.sv @@
// Weighted byte product and 64-bit running sum with the character position.
`default_nettype none
module pwsh_accum
  import pwsh_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pwsh_acc_ctl_t        ctl,
  input  wire logic [CharW-1:0]     char_byte,
  input  wire logic [DataW-1:0]     hash_magic,
  output logic      [SumW-1:0]      sum
);

  logic [DataW-1:0] pos_r, pos_nxt;
  logic [SumW-1:0]  sum_r, sum_nxt;
  logic [DataW-1:0] prod_r;
  logic [DataW-1:0] weight;
  logic [DataW-1:0] byte_ext;

  assign weight   = pos_r + hash_magic;
  assign byte_ext = {{(DataW-CharW){char_byte[CharW-1]}}, char_byte};

  // Low 32 bits of the product are the same for signed and unsigned operands.
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= weight * byte_ext;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (ctl.clear) begin
      pos_nxt = '0;
      sum_nxt = '0;
    end else if (ctl.acc_en) begin
      pos_nxt = pos_r + 32'd1;
      sum_nxt = sum_r + {{(SumW-DataW){1'b0}}, prod_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule
`default_nettype wire

@@ hw/rtl/pwsh_mod_unit.sv @@
// Bit-serial restoring remainder unit: 64-bit dividend modulo 32-bit divisor.
`default_nettype none
`include "position_weighted_string_hash_core_assert.svh"
module pwsh_mod_unit
  import pwsh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SumW-1:0]   dividend,
  input  wire logic [DataW-1:0]  divisor,
  output pwsh_div_sts_t          sts,
  output logic      [DataW-1:0]  remainder
);

  localparam int unsigned CntW = $clog2(SumW);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [SumW-1:0]   dvd_r, dvd_nxt;
  logic [DataW-1:0]  rem_r, rem_nxt;
  logic [DataW:0]    trial;
  logic [DataW:0]    diff;
  logic              ge;

  // One quotient bit per cycle; only the partial remainder is kept.
  assign trial = {rem_r, dvd_r[SumW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DataW-1:0] : trial[DataW-1:0];
      dvd_nxt = {dvd_r[SumW-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(SumW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign remainder = rem_r;

  `PWSH_ASSERT_NEXT(a_start_busy, start, busy_r, "remainder unit did not start")
  `PWSH_ASSERT(a_done_idle, done_r |-> !busy_r, "done raised while still busy")
  `PWSH_ASSERT(a_rem_range, (done_r && divisor != '0) |-> (rem_r < divisor), "remainder too large")

endmodule
`default_nettype wire

@@ dv/tb_position_weighted_string_hash_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the position-weighted string hash core.
module tb_position_weighted_string_hash_core;
  import pwsh_pkg::*;

  localparam int SETTLE_CYCLES   = 100;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int NUM_PHASES      = 7;
  localparam int WORDS_PER_PHASE = 215;

  // Keeps its own copy of the hash state and the registers. Every accepted
  // input word is folded in, and each finished string queues its bucket.
  class bucket_scoreboard;
    bit [31:0] magic = MAGIC_RESET;
    bit [31:0] buckets = BUCKETS_RESET;
    bit [63:0] sum = '0;
    bit [31:0] position = '0;
    bit [31:0] expected_buckets[$];
    int mismatches = 0;
    int bytes_hashed = 0;
    int strings_closed = 0;
    int buckets_checked = 0;

    function void set_register(logic idx, bit [31:0] value);
      if (idx == CFG_HASH_MAGIC) begin
        magic = value;
      end else begin
        buckets = value;
      end
    endfunction

    function void note_word(logic [7:0] ch, logic has_char, logic last_char);
      bit [31:0] weight;
      bit [31:0] widened;
      bit [31:0] product;
      if (has_char) begin
        // The byte counts as a signed char; the product wraps at 32 bits.
        weight = position + magic;
        widened = {{24{ch[7]}}, ch};
        product = weight * widened;
        sum += {32'd0, product};
        position += 32'd1;
        bytes_hashed++;
      end
      if (last_char) begin
        if (buckets == 32'd0) begin
          expected_buckets.push_back(32'd0);
        end else begin
          expected_buckets.push_back(32'(sum % {32'd0, buckets}));
        end
        sum = '0;
        position = '0;
        strings_closed++;
      end
    endfunction

    function void check_bucket(logic [31:0] got);
      bit [31:0] want;
      if (expected_buckets.size() == 0) begin
        $error("bucket: expected nothing, actual %0d", got);
        mismatches++;
        return;
      end
      want = expected_buckets.pop_front();
      buckets_checked++;
      if (got !== want) begin
        $error("bucket: expected %0d, actual %0d", want, got);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_buckets.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // char_byte[7:0]
  logic        in_tuser = 1'b0;  // has_char
  logic        in_tlast = 1'b0;  // last_char
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // bucket[31:0]
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_HASH_MAGIC;
  logic [31:0] cfg_wdata = '0;

  bucket_scoreboard sb = new();
  int send_calm = 0;
  int drain_calm = 0;
  int settings_used = 1;

  position_weighted_string_hash_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both handshakes are sampled right at the edge, before any update lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_word(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) sb.check_bucket(out_tdata);
    end
  end

  // Random wait before each word, with occasional runs of back-to-back words.
  function automatic int pick_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 5);
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 15))
      0: return 8'h00;
      1: return 8'h7f;
      2: return 8'h80;
      3: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(40, 120);
    return $urandom_range(1, 12);
  endfunction

  task automatic send_word(input logic [7:0] ch, input logic has_char, input logic last_char);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= ch;
    in_tuser <= has_char;
    in_tlast <= last_char;
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  // One string; idle words may fall before any of its bytes, and it ends either on
  // its last byte or on a separate word that carries no character.
  task automatic send_string(input int len, output int sent);
    int i;
    bit split_end;
    sent = 0;
    split_end = (len == 0) || ($urandom_range(0, 3) == 0);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(pick_char(), 1'b1, !split_end && (i == len - 1));
      sent++;
    end
    if (split_end) begin
      send_word(8'($urandom), 1'b0, 1'b1);
      sent++;
    end
  endtask

  // Registers change only once every bucket is out and the pipeline is empty.
  // The extra edge lets the monitor note the word taken at the last edge.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write_both(input bit [31:0] magic, input bit [31:0] buckets);
    cfg_we <= 1'b1;
    cfg_index <= CFG_HASH_MAGIC;
    cfg_wdata <= magic;
    @(posedge clk);
    sb.set_register(CFG_HASH_MAGIC, magic);
    cfg_index <= CFG_BUCKET_COUNT;
    cfg_wdata <= buckets;
    @(posedge clk);
    sb.set_register(CFG_BUCKET_COUNT, buckets);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    bit [31:0] phase_magic[NUM_PHASES];
    bit [31:0] phase_buckets[NUM_PHASES];
    int p;
    int sent;
    int n;
    int k;

    phase_magic = '{32'd0, 32'hffff_ffff, 32'hffff_ff00, 32'h8000_0000,
                    32'($urandom), 32'($urandom), 32'd47};
    phase_buckets = '{32'd1, 32'hffff_ffff, 32'd0, 32'h8000_0000,
                      32'($urandom), 32'($urandom_range(1, 100)), 32'd7};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset values of the registers.
    send_word(8'ha5, 1'b0, 1'b1);   // empty string gives bucket 0
    send_word(8'h5a, 1'b0, 1'b0);   // idle word, no result
    send_word(8'h41, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b0);   // zero byte still moves the position
    send_word(8'h7f, 1'b1, 1'b0);
    send_word(8'h80, 1'b1, 1'b0);
    send_word(8'hff, 1'b1, 1'b0);
    send_word(8'h3c, 1'b0, 1'b0);
    send_word(8'h01, 1'b1, 1'b1);
    for (k = 0; k < 6; k++) send_word(8'hff, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h80, 1'b1, 1'b0);
    send_word(8'h80, 1'b1, 1'b1);

    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      cfg_write_both(phase_magic[p], phase_buckets[p]);
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        send_string(pick_length(), n);
        sent += n;
      end
    end

    settle();

    $display("Hashed %0d strings holding %0d bytes under %0d register settings.",
             sb.strings_closed, sb.bytes_hashed, settings_used);
    $display("Checked %0d buckets, %0d mismatches.", sb.buckets_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("position_weighted_string_hash_core test passed");
    end else begin
      $display("position_weighted_string_hash_core test failed");
    end
    $finish;
  end

  // Result side: random stalls, plus two long hold-offs so that the core
  // backs up and has to refuse input words.
  initial begin : drain
    int gap;
    int taken;
    taken = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = pick_gap(drain_calm);
      if (taken == 12 || taken == 90) gap = HOLD_OFF_CYCLES;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      taken++;
    end
  end

  initial begin : watchdog
    #8ms;
    $display("position_weighted_string_hash_core test failed");
    $finish;
  end

endmodule
